// File: rtl/icmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_pkg
// shared types, constants and checksum helpers for the icmp echo responder
// ----------------------------------------------------------------------------
package icmp_pkg;

    localparam int unsigned COUNT_WIDTH_DEF     = 32;
    localparam logic [15:0] MAX_PAYLOAD_DEF     = 16'd1400;
    localparam logic [7:0]  ECHO_REQUEST_TYPE   = 8'd8;
    localparam logic [15:0] INDEX_MAX           = 16'hFFFF;
    localparam logic [15:0] CSUM_GOOD           = 16'hFFFF;
    localparam logic [31:0] REPLY_CSUM_ADJUST   = 32'h0000_0800;
    localparam int unsigned QUEUE_DEPTH         = 4;
    localparam int unsigned QUEUE_AW            = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_TYPE = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_SHORT    = 2'd3
    } t_status;

    typedef struct packed {
        logic        reply_valid;
        logic [7:0]  reply_byte;
        logic        reply_last;
        logic        status_valid;
        t_status     status;
        logic        checksum_ok;
        logic [31:0] bad_type_count;
        logic [31:0] bad_checksum_count;
    } t_result;

    // ones'-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'b0, s[16]};
        return f[15:0];
    endfunction

    // reply checksum: complement, take off 0x800, fold twice, complement again
    function automatic logic [15:0] reply_checksum(input logic [15:0] orig);
        logic [31:0] t;
        logic [16:0] f1;
        logic [16:0] f2;
        t  = {16'hFFFF, ~orig} - REPLY_CSUM_ADJUST;
        f1 = {1'b0, t[15:0]} + {1'b0, t[31:16]};
        f2 = {1'b0, f1[15:0]} + {16'b0, f1[16]};
        return ~f2[15:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/icmp_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_out_queue
// small result queue, up to two results in per cycle, one out per ready cycle
// ----------------------------------------------------------------------------
module icmp_out_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  [1:0]             i_push_cnt,
    input  icmp_pkg::t_result      i_push0,
    input  icmp_pkg::t_result      i_push1,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire                    i_ready,
    output icmp_pkg::t_result      o_head
);
    import icmp_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]     r_count,  n_count;
    logic                  pop;
    logic [QUEUE_AW-1:0]   wr_ptr1;

    assign pop     = o_valid && i_ready;
    assign wr_ptr1 = r_wr_ptr + QUEUE_AW'(1);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    // room for two more regardless of the output side
    assign o_room  = (r_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_AW'(i_push_cnt);
        n_rd_ptr = pop ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_count  = r_count + (QUEUE_AW + 1)'(i_push_cnt) - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_push1;
        end
    end

endmodule
`default_nettype wire

// File: rtl/icmp_echo_responder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_echo_responder
// checks an icmp message byte stream and streams back the echo reply
// ----------------------------------------------------------------------------
// results are written into the result queue as their bytes are transferred
// throughput: one byte per cycle while the queue has room; byte 3 of an echo
//   request gives two results and the four-entry result queue absorbs the extra one
// s_axis_tready drops only when the result queue holds more than two entries
// reset is synchronous, active low: clears message state, counters and queue,
//   and sets max_payload back to 1400
module icmp_echo_responder #(
    parameter int unsigned COUNT_WIDTH = icmp_pkg::COUNT_WIDTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // configuration: max_payload
    input  wire          i_cfg_wr_en,
    input  wire  [15:0]  i_cfg_wr_data,
    // message bytes in
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire          s_axis_tlast,   // last
    // reply and status out
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [79:0]  m_axis_tdata,   // [7:0] reply_byte, [9:8] status,
                                         // [10] checksum_ok,
                                         // [42:11] bad_type_count,
                                         // [74:43] bad_checksum_count, rest zero
    output logic [1:0]   m_axis_tuser,   // [0] reply_valid, [1] status_valid
    output logic         m_axis_tlast    // reply_last
);
    import icmp_pkg::*;

    // configuration register
    logic [15:0]            r_max_payload;

    // per-message state
    logic [15:0]            r_byte_index, n_byte_index;
    logic                   r_odd_phase,  n_odd_phase;
    logic [15:0]            r_word_sum,   n_word_sum;
    logic [7:0]             r_pending,    n_pending;
    logic                   r_is_echo,    n_is_echo;

    // statistics, wrap at COUNT_WIDTH bits
    logic [COUNT_WIDTH-1:0] r_bad_type,   n_bad_type;
    logic [COUNT_WIDTH-1:0] r_bad_csum,   n_bad_csum;

    logic                   accept;
    logic [7:0]             b;
    logic                   last;
    logic                   echo;
    logic                   over;
    logic [15:0]            idx_less_hdr;
    logic [15:0]            word;
    logic                   add_en;
    logic [15:0]            sum_after;
    logic                   long_enough;
    logic                   ck_ok;
    t_status                status;
    logic [15:0]            reply_csum;
    logic [1:0]             n_reply;      // reply bytes this byte produces
    logic [1:0]             n_total;      // results this byte produces
    logic [1:0]             push_cnt;
    logic                   queue_room;
    logic                   queue_valid;
    t_result                res0, res1, head;

    assign b      = s_axis_tdata;
    assign last   = s_axis_tlast;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = queue_room;

    // config write; the user writes only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_DEF;
        end else if (i_cfg_wr_en) begin
            r_max_payload <= i_cfg_wr_data;
        end
    end

    // byte classification
    always_comb begin
        echo         = (r_byte_index == 16'd0) ? (b == ECHO_REQUEST_TYPE) : r_is_echo;
        idx_less_hdr = r_byte_index - 16'd4;
        // payload beyond the bound, or position counter saturated
        over         = (r_byte_index == INDEX_MAX) ||
                       ((r_byte_index >= 16'd4) && (idx_less_hdr >= r_max_payload));
        long_enough  = (r_byte_index >= 16'd3);
    end

    // running ones'-complement word sum; odd trailing byte is the high byte
    always_comb begin
        word      = r_odd_phase ? {r_pending, b} : {b, 8'h00};
        add_en    = r_odd_phase || last;
        sum_after = add_en ? ones_add(r_word_sum, word) : r_word_sum;
        ck_ok     = long_enough && (sum_after == CSUM_GOOD);
    end

    // closing status, short beats bad type beats too long
    always_comb begin
        if (!long_enough) begin
            status = ST_SHORT;
        end else if (!echo) begin
            status = ST_BAD_TYPE;
        end else if (over) begin
            status = ST_TOO_LONG;
        end else begin
            status = ST_OK;
        end
    end

    // counters as they stand after this byte
    always_comb begin
        n_bad_type = r_bad_type;
        n_bad_csum = r_bad_csum;
        if (last && long_enough) begin
            if (!ck_ok) begin
                n_bad_csum = r_bad_csum + COUNT_WIDTH'(1);
            end
            if (!echo) begin
                n_bad_type = r_bad_type + COUNT_WIDTH'(1);
            end
        end
    end

    // reply bytes: zero type and code, new checksum at byte 3, then payload
    // at byte 3 r_pending still holds byte 2, the checksum high byte
    assign reply_csum = reply_checksum({r_pending, b});

    always_comb begin
        n_reply = 2'd0;
        if (echo) begin
            if (r_byte_index <= 16'd1) begin
                n_reply = 2'd1;
            end else if (r_byte_index == 16'd3) begin
                n_reply = 2'd2;
            end else if ((r_byte_index >= 16'd4) && !over) begin
                n_reply = 2'd1;
            end
        end
        // a closing byte with no reply byte still carries the status
        n_total  = (last && (n_reply == 2'd0)) ? 2'd1 : n_reply;
        push_cnt = accept ? n_total : 2'd0;
    end

    always_comb begin
        res0                    = '0;
        res0.reply_valid        = (n_reply != 2'd0);
        // a status-only result carries a zero byte
        if (!res0.reply_valid) begin
            res0.reply_byte     = 8'h00;
        end else if (r_byte_index == 16'd3) begin
            res0.reply_byte     = reply_csum[15:8];
        end else if (r_byte_index >= 16'd4) begin
            res0.reply_byte     = b;
        end else begin
            res0.reply_byte     = 8'h00;
        end
        res0.reply_last         = last && (n_reply == 2'd1);
        res0.status_valid       = last && (n_total == 2'd1);
        res0.status             = res0.status_valid ? status : ST_OK;
        res0.checksum_ok        = res0.status_valid && ck_ok;
        res0.bad_type_count     = 32'(n_bad_type);
        res0.bad_checksum_count = 32'(n_bad_csum);

        // second result only for the low checksum byte
        res1                    = '0;
        res1.reply_valid        = 1'b1;
        res1.reply_byte         = reply_csum[7:0];
        res1.reply_last         = last;
        res1.status_valid       = last;
        res1.status             = last ? status : ST_OK;
        res1.checksum_ok        = last && ck_ok;
        res1.bad_type_count     = 32'(n_bad_type);
        res1.bad_checksum_count = 32'(n_bad_csum);
    end

    // next message state
    always_comb begin
        n_byte_index = r_byte_index;
        n_odd_phase  = r_odd_phase;
        n_word_sum   = r_word_sum;
        n_pending    = r_pending;
        n_is_echo    = r_is_echo;
        if (last) begin
            n_byte_index = '0;
            n_odd_phase  = 1'b0;
            n_word_sum   = '0;
            n_pending    = '0;
            n_is_echo    = 1'b0;
        end else begin
            if (r_byte_index != INDEX_MAX) begin
                n_byte_index = r_byte_index + 16'd1;
            end
            n_odd_phase = !r_odd_phase;
            n_word_sum  = sum_after;
            n_is_echo   = echo;
            if (!r_odd_phase) begin
                n_pending = b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_odd_phase  <= 1'b0;
            r_word_sum   <= '0;
            r_pending    <= '0;
            r_is_echo    <= 1'b0;
            r_bad_type   <= '0;
            r_bad_csum   <= '0;
        end else if (accept) begin
            r_byte_index <= n_byte_index;
            r_odd_phase  <= n_odd_phase;
            r_word_sum   <= n_word_sum;
            r_pending    <= n_pending;
            r_is_echo    <= n_is_echo;
            r_bad_type   <= n_bad_type;
            r_bad_csum   <= n_bad_csum;
        end
    end

    // result queue parts the two sides
    icmp_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push0    (res0),
        .i_push1    (res1),
        .o_room     (queue_room),
        .o_valid    (queue_valid),
        .i_ready    (m_axis_tready),
        .o_head     (head)
    );

    assign m_axis_tvalid = queue_valid;
    assign m_axis_tlast  = head.reply_last;
    assign m_axis_tuser  = {head.status_valid, head.reply_valid};
    assign m_axis_tdata  = {5'b0, head.bad_checksum_count, head.bad_type_count,
                            head.checksum_ok, head.status, head.reply_byte};

endmodule
`default_nettype wire
